@@ rtl/null_symbol_frame_sync_assert.svh @@
// Assertion macros shared by the frame sync modules.
`ifndef NULL_SYMBOL_FRAME_SYNC_ASSERT_SVH
`define NULL_SYMBOL_FRAME_SYNC_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define NSFS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("frame sync assertion failed");

// Consequent holds at the same edge as the antecedent.
`define NSFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame sync assertion failed");

`endif

@@ rtl/nsfs_pkg.sv @@
// Types and constants shared by the null symbol frame sync modules.
package nsfs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PWR_W      = 2 * SAMPLE_W;
    localparam int NL_W       = 13;
    localparam int LOOK_W     = 7;
    localparam int FALL_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [FALL_W-1:0] FALL_MAX = 13'd8191;
    localparam logic [NL_W-1:0]   NL_RESET = 13'd2656;
    localparam logic [LOOK_W-1:0] LA_RESET = 7'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_NULL_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMP_DIST    = 2'd1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample            sample_i;
        t_sample            sample_q;
        logic [PWR_W-1:0]   pwr;
    } t_front_word;

    typedef struct packed {
        logic [NL_W-1:0]    null_length;
        logic [LOOK_W-1:0]  cmp_dist;
        logic               clear;
    } t_cfg;

endpackage

@@ rtl/nsfs_if.sv @@
// Stream and configuration interfaces of the null symbol frame sync.
interface nsfs_in_if
    import nsfs_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample_i;
    t_sample sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface nsfs_out_if
    import nsfs_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample delayed_i;
    t_sample delayed_q;
    logic    frame_start;

    modport source (output valid, output delayed_i, output delayed_q, output frame_start,
                    input ready);
    modport sink (input valid, input delayed_i, input delayed_q, input frame_start,
                  output ready);
endinterface

interface nsfs_cfg_if
    import nsfs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/nsfs_fifo.sv @@
// Short queue between the power front end and the detection back end.
`include "null_symbol_frame_sync_assert.svh"

module nsfs_fifo
    import nsfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push_valid,
    input  t_front_word i_push_data,
    output logic        o_push_ready,
    output logic        o_pop_valid,
    output t_front_word o_pop_data,
    input  logic        i_pop_ready
);

    t_front_word          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_count;
    logic                 push;
    logic                 pop;

    assign o_push_ready = (r_count != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `NSFS_ASSERT_ALWAYS(a_fifo_count_range, i_clk, i_rst_n, r_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    `NSFS_ASSERT_IMPLY(a_fifo_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_wr == r_rd)
    `NSFS_ASSERT_IMPLY(a_fifo_full_ptrs, i_clk, i_rst_n, !o_push_ready, r_wr == r_rd)

endmodule

@@ rtl/nsfs_front.sv @@
// Front end: takes sample words and forms their instantaneous power.
module nsfs_front
    import nsfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsfs_in_if.sink     i_smp,
    output logic        o_push_valid,
    output t_front_word o_push_data,
    input  logic        i_push_ready
);

    logic                       r_f1_v;
    t_sample                    r_f1_i;
    t_sample                    r_f1_q;
    logic                       r_f2_v;
    t_front_word                r_f2;
    logic                       adv;
    logic signed [PWR_W-1:0]    sq_i;
    logic signed [PWR_W-1:0]    sq_q;
    logic [PWR_W-1:0]           pwr;

    // Both stages move together; the queue's back pressure stalls them.
    assign adv         = !r_f2_v || i_push_ready;
    assign i_smp.ready = adv;

    // Each square is at most 2^30, so the sum fits in PWR_W bits unsigned.
    assign sq_i = r_f1_i * r_f1_i;
    assign sq_q = r_f1_q * r_f1_q;
    assign pwr  = $unsigned(sq_i) + $unsigned(sq_q);

    assign o_push_valid = r_f2_v;
    assign o_push_data  = r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (adv) begin
            r_f1_v <= i_smp.valid;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1_i       <= i_smp.sample_i;
            r_f1_q       <= i_smp.sample_q;
            r_f2.sample_i <= r_f1_i;
            r_f2.sample_q <= r_f1_q;
            r_f2.pwr      <= pwr;
        end
    end

endmodule

@@ rtl/nsfs_back.sv @@
// Back end: moving power sum, delayed sum comparison, fall counter and sample delay.
`include "null_symbol_frame_sync_assert.svh"

module nsfs_back
    import nsfs_pkg::*;
#(
    parameter int MAX_WINDOW   = 4096,
    parameter int MAX_CMP_DIST = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_pop_valid,
    input  t_front_word i_pop_data,
    output logic        o_pop_ready,
    nsfs_out_if.source  o_res
);

    localparam int WIN_AW     = $clog2(MAX_WINDOW);
    localparam int WIN_CW     = $clog2(MAX_WINDOW + 1);
    localparam int WIN_SW     = WIN_AW + 1;
    localparam int SUM_W      = PWR_W + WIN_AW;
    localparam int HIST_AW    = $clog2(MAX_CMP_DIST + 1);
    localparam int HIST_DEPTH = 2 ** HIST_AW;
    localparam int SMP2_W     = 2 * SAMPLE_W;
    localparam int THR_XW     = WIN_CW + 2;
    localparam int THR_K      = THR_XW + 2;
    localparam int THR_M      = (2 ** THR_K + 4) / 5;
    localparam int THR_PW     = THR_XW + THR_K;
    localparam logic [THR_K-1:0] THR_MUL = THR_K'(THR_M);

    // Stores
    logic [PWR_W-1:0]    r_win_mem [MAX_WINDOW];
    logic [SMP2_W-1:0]   r_smp_mem [HIST_DEPTH];
    logic [SUM_W-1:0]    r_sum_mem [HIST_DEPTH];
    logic [PWR_W-1:0]    r_win_rd;
    logic [SMP2_W-1:0]   r_smp_rd;
    logic [SUM_W-1:0]    r_sum_rd;

    // Running state
    logic [WIN_AW-1:0]   r_wptr;
    logic [WIN_CW-1:0]   r_wfill;
    logic [SUM_W-1:0]    r_sum;
    logic [HIST_AW-1:0]  r_hptr;
    logic [HIST_AW-1:0]  r_hcnt;
    logic [FALL_W-1:0]   r_fall;
    logic [WIN_CW-1:0]   r_thr;

    // Pipeline stages
    logic                r_b2_v;
    logic [PWR_W-1:0]    r_b2_pwr;
    logic                r_b2_old_ok;
    logic [HIST_AW-1:0]  r_b2_hptr;
    logic                r_b2_zero;
    logic                r_b2_smp_ok;
    logic                r_b2_sum_ok;
    logic [SMP2_W-1:0]   r_b2_smp;
    logic                r_b3_v;
    logic [SUM_W-1:0]    r_b3_sum;
    logic [SMP2_W-1:0]   r_b3_dly;
    logic                r_b3_sum_ok;
    logic                r_o_valid;
    logic [SMP2_W-1:0]   r_o_dly;
    logic                r_o_start;

    logic                adv;
    logic                fire;
    logic [WIN_CW-1:0]   eff_n;
    logic [HIST_AW-1:0]  eff_la;
    logic [HIST_AW-1:0]  la_half;
    logic [WIN_CW-1:0]   win_dist;
    logic [WIN_SW-1:0]   win_osum;
    logic [WIN_AW-1:0]   old_idx;
    logic [WIN_AW-1:0]   n_wptr;
    logic [WIN_CW-1:0]   n_wfill;
    logic [HIST_AW-1:0]  n_hcnt;
    logic [SUM_W-1:0]    old_pwr;
    logic [SUM_W-1:0]    n_sum;
    logic [SMP2_W-1:0]   dly;
    logic [SUM_W-1:0]    old_sum;
    logic                start;
    logic [FALL_W-1:0]   n_fall;
    logic [THR_PW-1:0]   thr_prod;

    // The whole back end advances when the output register is free.
    assign adv         = !r_o_valid || o_res.ready;
    assign fire        = adv && i_pop_valid;
    assign o_pop_ready = adv;

    always_comb begin
        if (i_cfg.null_length == '0) begin
            eff_n = WIN_CW'(1);
        end else if (32'(i_cfg.null_length) > 32'(MAX_WINDOW)) begin
            eff_n = WIN_CW'(MAX_WINDOW);
        end else begin
            eff_n = WIN_CW'(i_cfg.null_length);
        end
        if (i_cfg.cmp_dist == '0) begin
            eff_la = HIST_AW'(1);
        end else if (32'(i_cfg.cmp_dist) > 32'(MAX_CMP_DIST)) begin
            eff_la = HIST_AW'(MAX_CMP_DIST);
        end else begin
            eff_la = HIST_AW'(i_cfg.cmp_dist);
        end
        la_half = eff_la >> 1;
    end

    // Oldest power of the window sits eff_n places behind the write pointer.
    always_comb begin
        win_dist = WIN_CW'(MAX_WINDOW) - eff_n;
        win_osum = WIN_SW'(r_wptr) + WIN_SW'(win_dist);
        if (win_osum >= WIN_SW'(MAX_WINDOW)) begin
            old_idx = WIN_AW'(win_osum - WIN_SW'(MAX_WINDOW));
        end else begin
            old_idx = WIN_AW'(win_osum);
        end
        n_wptr  = (r_wptr == WIN_AW'(MAX_WINDOW - 1)) ? '0 : r_wptr + 1'b1;
        n_wfill = (r_wfill == WIN_CW'(MAX_WINDOW)) ? r_wfill : r_wfill + 1'b1;
        n_hcnt  = (r_hcnt == HIST_AW'(MAX_CMP_DIST)) ? r_hcnt : r_hcnt + 1'b1;
    end

    // Threshold floor(4n/5) by a reciprocal multiply, exact over the whole range of n.
    assign thr_prod = THR_PW'({eff_n, 2'b00}) * THR_PW'(THR_MUL);

    // Entries beyond the fill counts were never written and stand for zero.
    always_comb begin
        old_pwr = r_b2_old_ok ? SUM_W'(r_win_rd) : '0;
        n_sum   = r_sum - old_pwr + SUM_W'(r_b2_pwr);
        if (r_b2_zero) begin
            dly = r_b2_smp;
        end else if (r_b2_smp_ok) begin
            dly = r_smp_rd;
        end else begin
            dly = '0;
        end
        old_sum = r_b3_sum_ok ? r_sum_rd : '0;
        start   = (32'(r_fall) > 32'(r_thr)) && (r_b3_sum > old_sum);
        if (r_b3_sum < old_sum) begin
            n_fall = (r_fall == FALL_MAX) ? r_fall : r_fall + 1'b1;
        end else begin
            n_fall = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_win_rd <= r_win_mem[old_idx];
            if (fire) begin
                r_win_mem[r_wptr] <= i_pop_data.pwr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_smp_rd <= r_smp_mem[r_hptr - la_half];
            if (fire) begin
                r_smp_mem[r_hptr] <= {i_pop_data.sample_q, i_pop_data.sample_i};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum_rd <= r_sum_mem[r_b2_hptr - eff_la];
            if (r_b2_v) begin
                r_sum_mem[r_b2_hptr] <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_v    <= 1'b0;
            r_b3_v    <= 1'b0;
            r_o_valid <= 1'b0;
            r_wptr    <= '0;
            r_wfill   <= '0;
            r_sum     <= '0;
            r_hptr    <= '0;
            r_hcnt    <= '0;
            r_fall    <= '0;
        end else begin
            if (adv) begin
                r_b2_v    <= i_pop_valid;
                r_b3_v    <= r_b2_v;
                r_o_valid <= r_b3_v;
            end
            if (i_cfg.clear) begin
                r_wptr  <= '0;
                r_wfill <= '0;
                r_sum   <= '0;
            end else begin
                if (fire) begin
                    r_wptr  <= n_wptr;
                    r_wfill <= n_wfill;
                end
                if (adv && r_b2_v) begin
                    r_sum <= n_sum;
                end
            end
            if (fire) begin
                r_hptr <= r_hptr + 1'b1;
                r_hcnt <= n_hcnt;
            end
            if (adv && r_b3_v) begin
                r_fall <= n_fall;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr <= WIN_CW'(thr_prod >> THR_K);
        if (adv) begin
            r_b2_pwr    <= i_pop_data.pwr;
            r_b2_old_ok <= (r_wfill >= eff_n);
            r_b2_hptr   <= r_hptr;
            r_b2_zero   <= (la_half == '0);
            r_b2_smp_ok <= (r_hcnt >= la_half);
            r_b2_sum_ok <= (r_hcnt >= eff_la);
            r_b2_smp    <= {i_pop_data.sample_q, i_pop_data.sample_i};
            r_b3_sum    <= n_sum;
            r_b3_dly    <= dly;
            r_b3_sum_ok <= r_b2_sum_ok;
            r_o_dly     <= r_b3_dly;
            r_o_start   <= start;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.delayed_i   = r_o_dly[SAMPLE_W-1:0];
    assign o_res.delayed_q   = r_o_dly[SMP2_W-1:SAMPLE_W];
    assign o_res.frame_start = r_o_start;

    `NSFS_ASSERT_ALWAYS(a_wfill_range, i_clk, i_rst_n, 32'(r_wfill) <= 32'(MAX_WINDOW))
    `NSFS_ASSERT_ALWAYS(a_hcnt_range, i_clk, i_rst_n, 32'(r_hcnt) <= 32'(MAX_CMP_DIST))
    `NSFS_ASSERT_IMPLY(a_start_clears_fall, i_clk, i_rst_n, r_o_valid && r_o_start, r_fall == '0)

endmodule

@@ rtl/null_symbol_frame_sync.sv @@
// Null symbol frame sync: one sample word per cycle in, one result word per cycle out,
// while the result side does not stall. A sample word passes through two front stages,
// one queue slot and three back stages. Throughput, while the result side does not stall:
// one word per cycle; the window sum closes its loop in a single back-end stage.
// Reset is synchronous and clears all control state; the power window and the delay lines
// read as zero until written, tracked by fill counts, so no clearing pass follows reset.
module null_symbol_frame_sync
    import nsfs_pkg::*;
#(
    parameter int MAX_WINDOW   = 4096,
    parameter int MAX_CMP_DIST = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsfs_in_if.sink     i_smp,
    nsfs_out_if.source  o_res,
    nsfs_cfg_if.sink    i_cfg
);

    logic [NL_W-1:0]   r_null_length;
    logic [LOOK_W-1:0] r_cmp_dist;
    logic              r_clear;
    t_cfg              cfg;
    logic              push_valid;
    logic              push_ready;
    t_front_word       push_data;
    logic              pop_valid;
    logic              pop_ready;
    t_front_word       pop_data;

    assign i_cfg.ready = 1'b1;

    // A new window size restarts the moving sum from an empty window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_length <= NL_RESET;
            r_cmp_dist    <= LA_RESET;
            r_clear       <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_NULL_LENGTH: begin
                        r_null_length <= i_cfg.data[NL_W-1:0];
                        r_clear       <= 1'b1;
                    end
                    CFG_CMP_DIST: begin
                        r_cmp_dist <= i_cfg.data[LOOK_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign cfg.null_length = r_null_length;
    assign cfg.cmp_dist    = r_cmp_dist;
    assign cfg.clear       = r_clear;

    nsfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp        (i_smp),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    nsfs_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    nsfs_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_CMP_DIST (MAX_CMP_DIST)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_pop_valid  (pop_valid),
        .i_pop_data   (pop_data),
        .o_pop_ready  (pop_ready),
        .o_res        (o_res)
    );

endmodule

@@ tb/null_symbol_frame_sync_tb.sv @@
// Self-checking testbench for the null symbol frame sync: directed and random sample streams.
`timescale 1ns / 100ps

module null_symbol_frame_sync_tb
    import nsfs_pkg::*;
();

    localparam int WIN_MAX      = 4096;
    localparam int LOOK_MAX     = 64;
    // A full window of maximum powers (2^31 each) needs 44 bits.
    localparam int SUM_W        = 44;
    localparam int CLK_PERIOD   = 2;
    localparam int IDLE_PCT     = 15;
    localparam int STALL_CYCLES = 300;
    localparam int RANDOM_ITEMS = 850;
    localparam int FALL_ITEMS   = 120;
    localparam int MAX_PRINTS   = 40;
    localparam int RUN_LIMIT_NS = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam t_sample SMP_MAX = 16'sh7FFF;
    localparam t_sample SMP_MIN = 16'sh8000;

    typedef struct {
        t_sample dly_i;
        t_sample dly_q;
        logic    start;
    } t_sync_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nsfs_in_if  smp_if ();
    nsfs_out_if res_if ();
    nsfs_cfg_if cfg_if ();

    null_symbol_frame_sync dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state.
    logic [PWR_W-1:0]      pwr_ring [WIN_MAX];
    logic [SUM_W-1:0]      ring_sum;
    logic [SUM_W-1:0]      sum_taps [LOOK_MAX+1];
    logic [2*SAMPLE_W-1:0] smp_taps [LOOK_MAX+1];
    logic [FALL_W-1:0]     dip_run;
    logic [11:0]           ring_wr;
    logic [NL_W-1:0]       nl_reg;
    logic [LOOK_W-1:0]     la_reg;

    t_sync_word awaited_words [$];
    int         mismatch_count = 0;
    int         words_seen     = 0;
    bit         no_idle        = 1'b0;
    bit         stall_req      = 1'b0;

    function automatic void clear_ring();
        foreach (pwr_ring[k]) pwr_ring[k] = '0;
        ring_sum = '0;
        ring_wr  = '0;
    endfunction

    function automatic void reset_predictor();
        clear_ring();
        foreach (sum_taps[k]) sum_taps[k] = '0;
        foreach (smp_taps[k]) smp_taps[k] = '0;
        dip_run = '0;
        nl_reg  = NL_RESET;
        la_reg  = LA_RESET;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_NULL_LENGTH) begin
            nl_reg = data[NL_W-1:0];
            clear_ring();
        end else if (idx == CFG_CMP_DIST) begin
            la_reg = data[LOOK_W-1:0];
        end
    endfunction

    function automatic t_sync_word compute_sync_word(input t_sample si, input t_sample sq);
        int unsigned      win;
        int unsigned      look;
        int unsigned      oldest;
        int unsigned      thresh;
        longint           pi;
        longint           pq;
        logic [PWR_W-1:0] pwr;
        logic [SUM_W-1:0] prior;
        t_sync_word       w;
        win  = (nl_reg == 0) ? 1 : (nl_reg > WIN_MAX) ? WIN_MAX : nl_reg;
        look = (la_reg == 0) ? 1 : (la_reg > LOOK_MAX) ? LOOK_MAX : la_reg;
        pi   = si;
        pq   = sq;
        pwr  = PWR_W'(pi * pi + pq * pq);

        for (int k = LOOK_MAX; k > 0; k--) smp_taps[k] = smp_taps[k-1];
        smp_taps[0] = {sq, si};

        // Drop the power that falls out of the window, add the new one.
        oldest   = (ring_wr + WIN_MAX - win) % WIN_MAX;
        ring_sum = ring_sum - SUM_W'(pwr_ring[oldest]) + SUM_W'(pwr);
        pwr_ring[ring_wr] = pwr;
        ring_wr  = ring_wr + 1'b1;

        for (int k = LOOK_MAX; k > 0; k--) sum_taps[k] = sum_taps[k-1];
        sum_taps[0] = ring_sum;
        prior  = sum_taps[look];
        thresh = win * 8 / 10;

        w.start = (dip_run > thresh) && (ring_sum > prior);
        if (ring_sum < prior) begin
            if (dip_run < FALL_MAX) dip_run = dip_run + 1'b1;
        end else begin
            dip_run = '0;
        end
        w.dly_i = smp_taps[look / 2][SAMPLE_W-1:0];
        w.dly_q = smp_taps[look / 2][2*SAMPLE_W-1:SAMPLE_W];
        return w;
    endfunction

    function automatic t_sample loud_part();
        int m;
        m = $urandom_range(8192, 32768);
        return $urandom_range(1) ? t_sample'(m) : t_sample'(-m);
    endfunction

    function automatic t_sample faint_part();
        int m;
        m = $urandom_range(0, 3);
        return $urandom_range(1) ? t_sample'(m) : t_sample'(-m);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Entered and left just after a falling edge.
    task automatic send_sample(input t_sample si, input t_sample sq);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            smp_if.valid = 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid    = 1'b1;
        smp_if.sample_i = si;
        smp_if.sample_q = sq;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        awaited_words.push_back(compute_sync_word(si, sq));
        @(negedge i_clk);
        smp_if.valid = 1'b0;
    endtask

    task automatic settle();
        while (awaited_words.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_reg_write(idx, data);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Loud body, a quiet stretch about one window long, then loud again.
    // A broken frame has a quiet stretch too short to reach the threshold.
    task automatic send_frame(input int win, input int look, input bit broken, output int sent);
        int body;
        int gap;
        int tail;
        body = win + $urandom_range(0, 8);
        if (broken) gap = $urandom_range(0, win / 2);
        else gap = win - look / 2 + $urandom_range(0, look);
        if (gap < 1) gap = 1;
        tail = look + $urandom_range(0, 8);
        repeat (body) send_sample(loud_part(), loud_part());
        repeat (gap) send_sample(faint_part(), faint_part());
        repeat (tail) send_sample(loud_part(), loud_part());
        sent = body + gap + tail;
    endtask

    always @(posedge i_clk) begin
        t_sync_word want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited_words.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with none expected", words_seen));
            end else begin
                want = awaited_words.pop_front();
                if (res_if.delayed_i !== want.dly_i)
                    report_mismatch($sformatf("word %0d delayed_i %0d, predicted %0d",
                                              words_seen, res_if.delayed_i, want.dly_i));
                if (res_if.delayed_q !== want.dly_q)
                    report_mismatch($sformatf("word %0d delayed_q %0d, predicted %0d",
                                              words_seen, res_if.delayed_q, want.dly_q));
                if (res_if.frame_start !== want.start)
                    report_mismatch($sformatf("word %0d frame_start %b, predicted %b",
                                              words_seen, res_if.frame_start, want.start));
            end
            words_seen++;
        end
    end

    // Result side: random idling, plus a long hold-off when asked for.
    initial begin : result_ready
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req  = 1'b0;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    task automatic test_reset_values();
        // Default settings; the first words come out of the zeroed history.
        send_sample(SMP_MAX, SMP_MAX);
        send_sample(SMP_MIN, SMP_MIN);
        send_sample(SMP_MIN, SMP_MAX);
        send_sample(SMP_MAX, SMP_MIN);
        send_sample('0, '0);
        send_sample(t_sample'(-1), t_sample'(-1));
        send_sample(t_sample'(1), '0);
        send_sample('0, t_sample'(1));
    endtask

    task automatic test_clamped_settings();
        // Zero settings act as one: the threshold is zero, so one fall and a rise mark a frame.
        write_reg(CFG_NULL_LENGTH, '0);
        write_reg(CFG_CMP_DIST, '0);
        send_sample(t_sample'(1000), '0);
        send_sample(t_sample'(10), '0);
        send_sample(t_sample'(2000), '0);
        send_sample('0, '0);
        send_sample(SMP_MIN, SMP_MIN);
        send_sample(SMP_MIN, SMP_MIN);
        send_sample(t_sample'(3), t_sample'(4));
        // Oversized settings saturate; the upper distance data bits are dropped.
        write_reg(CFG_NULL_LENGTH, 13'h1FFF);
        write_reg(CFG_CMP_DIST, 13'h1FFF);
        send_sample(SMP_MAX, SMP_MIN);
        send_sample(t_sample'(1), t_sample'(1));
        write_reg(CFG_NULL_LENGTH, 13'd4097);
        write_reg(CFG_CMP_DIST, 13'd65);
        send_sample(SMP_MIN, '0);
        send_sample('0, SMP_MAX);
    endtask

    task automatic test_window_rewrite();
        // Rewriting the window size must flush the powers already held.
        write_reg(CFG_NULL_LENGTH, 13'd4);
        write_reg(CFG_CMP_DIST, 13'd2);
        repeat (4) send_sample(SMP_MAX, SMP_MAX);
        write_reg(CFG_NULL_LENGTH, 13'd4);
        repeat (4) send_sample(t_sample'(5), t_sample'(-5));
    endtask

    task automatic test_spare_registers();
        write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom_range(0, 8191)));
        write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom_range(0, 8191)));
        repeat (4) send_sample(t_sample'($urandom), t_sample'($urandom));
    endtask

    task automatic test_long_fall();
        // A strictly falling power over a long run, then a rise marks a frame.
        write_reg(CFG_NULL_LENGTH, 13'd1);
        write_reg(CFG_CMP_DIST, 13'd1);
        for (int k = 0; k < FALL_ITEMS; k++) send_sample(SMP_MAX - t_sample'(k), '0);
        send_sample(SMP_MAX, '0);
        send_sample(SMP_MAX, '0);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_NULL_LENGTH, 13'd12);
        write_reg(CFG_CMP_DIST, 13'd6);
        stall_req = 1'b1;
        repeat (120) begin
            if ($urandom_range(1)) send_sample(loud_part(), loud_part());
            else send_sample(faint_part(), faint_part());
        end
    endtask

    task automatic test_random_frames();
        int total;
        int phase;
        int sent;
        int nl_data;
        int la_data;
        int win;
        int look;
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            if ($urandom_range(7) == 0) nl_data = $urandom_range(49, 160);
            else nl_data = $urandom_range(0, 48);
            la_data = $urandom_range(0, 8191);
            write_reg(CFG_NULL_LENGTH, CFG_DATA_W'(nl_data));
            write_reg(CFG_CMP_DIST, CFG_DATA_W'(la_data));
            win  = (nl_data == 0) ? 1 : nl_data;
            look = la_data % 128;
            look = (look == 0) ? 1 : (look > LOOK_MAX) ? LOOK_MAX : look;
            no_idle = (phase == 1);
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(4) == 0) begin
                    sent = $urandom_range(10, 60);
                    repeat (sent) send_sample(t_sample'($urandom), t_sample'($urandom));
                end else begin
                    send_frame(win, look, $urandom_range(5) == 0, sent);
                end
                total += sent;
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    task automatic test_full_window();
        // Largest window and comparison distance with loud random samples.
        write_reg(CFG_NULL_LENGTH, CFG_DATA_W'(WIN_MAX));
        write_reg(CFG_CMP_DIST, CFG_DATA_W'(LOOK_MAX));
        repeat (64) send_sample(loud_part(), loud_part());
    endtask

    initial begin : run_tests
        i_rst_n         = 1'b0;
        smp_if.valid    = 1'b0;
        smp_if.sample_i = '0;
        smp_if.sample_q = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_NULL_LENGTH;
        cfg_if.data     = '0;
        reset_predictor();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_clamped_settings();
        test_window_rewrite();
        test_spare_registers();
        test_long_fall();
        test_backpressure();
        test_random_frames();
        test_full_window();

        settle();
        repeat (16) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
